// ===== rtl/core/hpq_pkg.sv =====
// ----------------------------------------------------------------------------
// hpq_pkg: shared definitions for the binary max-heap priority queue
// Holds the operation codes, result status codes and payload types.
// ----------------------------------------------------------------------------
`default_nettype none

package hpq_pkg;

  typedef logic signed [31:0] value_t;
  typedef logic [1:0]         status_t;

  // Operation codes on in_func.
  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_POP  = 1'b1;

  // Result status codes.
  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_EMPTY = 2'd1;
  localparam status_t ST_FULL  = 2'd2;

  localparam int unsigned COUNT_OUT_W = 11;

endpackage : hpq_pkg

`default_nettype wire

// ===== rtl/core/max_heap_priority_queue.sv =====
// ----------------------------------------------------------------------------
// max_heap_priority_queue: binary max-heap of signed 32-bit values
// Push and pop-maximum operations on an array heap held in on-chip memory.
// ----------------------------------------------------------------------------
// Usage:
//   An item is a command on in_func (push or pop) with in_push_value. It is
//   taken at a rising edge where start is high and busy is low. Every item
//   gives exactly one result, shown for one cycle with out_valid high:
//   out_top_value (the popped maximum, zero otherwise), out_status (ok,
//   pop on empty, push on full) and out_entry_count (entries after the item).
//   The receiver cannot stall; the result must be taken in that cycle.
// Operation:
//   Errors and a push into an empty heap are done in the cycle they are
//   taken; their result is shown in the next cycle. A push climbs one
//   read-compare-write step per cycle, moving parents down, and writes the
//   value where it stops or at the root. A pop reads the root and the last
//   entry, then sinks the moved entry one step per cycle, or writes it
//   to the root if at most one entry is left. The block works on one item
//   at a time; busy is high while an item walks the heap, and the next
//   item can be taken in the cycle its result is shown.
// Reset:
//   rst_n clears the entry count and the control state; the memory is not
//   cleared since only entries below the count are ever used.
// ----------------------------------------------------------------------------
`default_nettype none

module max_heap_priority_queue #(
  parameter int unsigned HEAP_DEPTH = 1024
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   start,
  output logic                  busy,
  input  wire                   in_func,
  input  wire hpq_pkg::value_t  in_push_value,
  output logic                  out_valid,
  output hpq_pkg::value_t       out_top_value,
  output hpq_pkg::status_t      out_status,
  output logic [10:0]           out_entry_count
);

  // Index width, count width (holds HEAP_DEPTH itself) and child math width.
  localparam int unsigned AW = $clog2(HEAP_DEPTH);
  localparam int unsigned CW = $clog2(HEAP_DEPTH + 1);
  localparam int unsigned XW = AW + 2;
  localparam int unsigned OW = hpq_pkg::COUNT_OUT_W;

  // Sequencer states.
  localparam logic [2:0] S_IDLE  = 3'd0;  // waiting for an item
  localparam logic [2:0] S_UP    = 3'd1;  // sift-up compare against parent
  localparam logic [2:0] S_POPLD = 3'd2;  // root and last entry arrive
  localparam logic [2:0] S_DOWN  = 3'd3;  // sift-down compare against children
  localparam logic [2:0] S_FIN   = 3'd4;  // drop the moving value into its slot

  logic [2:0]          state_r, state_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [AW-1:0]       pos_r, pos_nxt;      // current hole position
  hpq_pkg::value_t     val_r, val_nxt;      // value being sifted
  hpq_pkg::value_t     top_r, top_nxt;      // popped maximum

  logic                out_valid_r, out_valid_nxt;
  hpq_pkg::value_t     out_top_r, out_top_nxt;
  hpq_pkg::status_t    out_status_r, out_status_nxt;
  logic [OW-1:0]       out_count_r, out_count_nxt;

  // Memory port controls.
  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  hpq_pkg::value_t     mem_wdata;
  logic [AW-1:0]       mem_ra0;
  logic [AW-1:0]       mem_ra1;
  hpq_pkg::value_t     mem_rd0;
  hpq_pkg::value_t     mem_rd1;

  hpq_mem #(
    .DEPTH (HEAP_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk      (clk),
    .wr_en    (mem_we),
    .wr_addr  (mem_waddr),
    .wr_data  (mem_wdata),
    .rd0_addr (mem_ra0),
    .rd1_addr (mem_ra1),
    .rd0_data (mem_rd0),
    .rd1_data (mem_rd1)
  );

  // Helper values for the walk. The count is widened so that child indexes,
  // which may run past the last entry, compare correctly.
  logic [XW-1:0]       count_x;
  logic [AW-1:0]       count_idx;
  logic [AW-1:0]       last_idx;
  logic [AW-1:0]       pos_parent;
  logic [AW-1:0]       count_parent;
  logic                right_ok;
  logic                pick_right;
  logic [AW-1:0]       pick_idx;
  hpq_pkg::value_t     pick_val;
  logic [AW-1:0]       desc_pos;
  logic [XW-1:0]       desc_left;
  logic [XW-1:0]       desc_right;
  logic [XW-1:0]       pos_right;
  logic [CW+OW-1:0]    count_ext;

  always_comb begin
    count_x      = {{(XW-CW){1'b0}}, count_r};
    count_idx    = count_r[AW-1:0];
    last_idx     = AW'(count_r - CW'(1));
    pos_parent   = AW'((pos_r - AW'(1)) >> 1);
    count_parent = AW'((count_idx - AW'(1)) >> 1);
    // Children of the current hole, compared in the sift-down step.
    pos_right    = {1'b0, pos_r, 1'b1} + XW'(1);
    right_ok     = (pos_right < count_x);
    pick_right   = right_ok && (mem_rd1 > mem_rd0);
    pick_idx     = pick_right ? pos_right[AW-1:0] : AW'({pos_r, 1'b1});
    pick_val     = pick_right ? mem_rd1 : mem_rd0;
    // Next level down: from the root after the load, else from the pick.
    desc_pos     = (state_r == S_POPLD) ? '0 : pick_idx;
    desc_left    = {1'b0, desc_pos, 1'b1};
    desc_right   = desc_left + XW'(1);
  end

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    pos_nxt        = pos_r;
    val_nxt        = val_r;
    top_nxt        = top_r;
    out_valid_nxt  = 1'b0;
    out_top_nxt    = '0;
    out_status_nxt = hpq_pkg::ST_OK;
    mem_we         = 1'b0;
    mem_waddr      = pos_r;
    mem_wdata      = val_r;
    mem_ra0        = desc_left[AW-1:0];
    mem_ra1        = desc_right[AW-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          if (in_func == hpq_pkg::FUNC_PUSH) begin
            top_nxt = '0;
            if (count_r == CW'(HEAP_DEPTH)) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = hpq_pkg::ST_FULL;
            end else if (count_r == '0) begin
              // Empty heap: the value lands straight at the root.
              mem_we        = 1'b1;
              mem_waddr     = '0;
              mem_wdata     = in_push_value;
              count_nxt     = CW'(1);
              out_valid_nxt = 1'b1;
            end else begin
              val_nxt   = in_push_value;
              pos_nxt   = count_idx;
              count_nxt = count_r + CW'(1);
              mem_ra0   = count_parent;
              state_nxt = S_UP;
            end
          end else begin
            if (count_r == '0) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = hpq_pkg::ST_EMPTY;
            end else begin
              mem_ra0   = '0;
              mem_ra1   = last_idx;
              count_nxt = count_r - CW'(1);
              state_nxt = S_POPLD;
            end
          end
        end
      end

      S_UP: begin
        if (val_r > mem_rd0) begin
          // Parent moves down into the hole; the hole climbs.
          mem_we    = 1'b1;
          mem_wdata = mem_rd0;
          pos_nxt   = pos_parent;
          mem_ra0   = AW'((pos_parent - AW'(1)) >> 1);
          if (pos_parent == '0) begin
            state_nxt = S_FIN;
          end
        end else begin
          mem_we        = 1'b1;
          out_valid_nxt = 1'b1;
          out_top_nxt   = top_r;
          state_nxt     = S_IDLE;
        end
      end

      S_POPLD: begin
        // The last entry becomes the moving value, the hole sits at the root.
        top_nxt = mem_rd0;
        val_nxt = mem_rd1;
        pos_nxt = '0;
        if (desc_left >= count_x) begin
          mem_we        = 1'b1;
          mem_waddr     = '0;
          mem_wdata     = mem_rd1;
          out_valid_nxt = 1'b1;
          out_top_nxt   = mem_rd0;
          state_nxt     = S_IDLE;
        end else begin
          state_nxt = S_DOWN;
        end
      end

      S_DOWN: begin
        if (pick_val > val_r) begin
          // Larger child moves up into the hole; the hole sinks.
          mem_we    = 1'b1;
          mem_wdata = pick_val;
          pos_nxt   = pick_idx;
          if (desc_left >= count_x) begin
            state_nxt = S_FIN;
          end
        end else begin
          mem_we        = 1'b1;
          out_valid_nxt = 1'b1;
          out_top_nxt   = top_r;
          state_nxt     = S_IDLE;
        end
      end

      S_FIN: begin
        mem_we        = 1'b1;
        out_valid_nxt = 1'b1;
        out_top_nxt   = top_r;
        state_nxt     = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    count_ext     = {{OW{1'b0}}, count_nxt};
    out_count_nxt = count_ext[OW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r <= pos_nxt;
    val_r <= val_nxt;
    top_r <= top_nxt;
    if (out_valid_nxt) begin
      out_top_r    <= out_top_nxt;
      out_status_r <= out_status_nxt;
      out_count_r  <= out_count_nxt;
    end
  end

  assign busy            = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_top_value   = out_top_r;
  assign out_status      = out_status_r;
  assign out_entry_count = out_count_r;

endmodule : max_heap_priority_queue

`default_nettype wire

// ===== rtl/core/hpq_mem.sv =====
// ----------------------------------------------------------------------------
// hpq_mem: heap entry storage
// Synchronous memory with one write port and two read ports; read data is
// registered and appears in the cycle after the address.
// ----------------------------------------------------------------------------
`default_nettype none

module hpq_mem #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  wire                  clk,
  input  wire                  wr_en,
  input  wire  [AW-1:0]        wr_addr,
  input  wire hpq_pkg::value_t wr_data,
  input  wire  [AW-1:0]        rd0_addr,
  input  wire  [AW-1:0]        rd1_addr,
  output hpq_pkg::value_t      rd0_data,
  output hpq_pkg::value_t      rd1_data
);

  hpq_pkg::value_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd0_data <= mem[rd0_addr];
    rd1_data <= mem[rd1_addr];
  end

endmodule : hpq_mem

`default_nettype wire
